>>> rtl/core/assert_macros.svh
// Assertion macros used by the quaternion rotation top level.
// No dependencies; expects the including scope to provide clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Concurrent check on clk, masked while rst is high.
`define QSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Concurrent check on clk that also holds through reset.
`define QSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define QSR_ASSERT(lbl, prop, msg)
`define QSR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/core/qsr_pkg.sv
// Types and fixed widths of the quaternion rotation pipeline.
// No dependencies; used by qsr_hsum, qsr_round and the top level under rtl/core.
package qsr_pkg;

  localparam int ROT_W   = 16;
  localparam int VAL_W   = 24;
  localparam int PROD1_W = ROT_W + VAL_W;
  localparam int SUM1_W  = PROD1_W + 2;
  localparam int PROD2_W = SUM1_W + ROT_W;
  localparam int SUM2_W  = PROD2_W + 2;

  // Subtract flags of a Hamilton product: [component][term].
  // Term t of component c multiplies operand t by operand t xor c.
  typedef logic [3:0][3:0] neg_map_t;

  // q * v
  localparam neg_map_t NEG_FIRST  = '{4'b0100, 4'b0010, 4'b1000, 4'b1110};
  // p * conj(q), conjugate signs folded into the flags
  localparam neg_map_t NEG_SECOND = '{4'b0011, 4'b1001, 4'b0101, 4'b0000};

  typedef struct packed {
    logic signed [ROT_W-1:0] rot_w;
    logic signed [ROT_W-1:0] rot_x;
    logic signed [ROT_W-1:0] rot_y;
    logic signed [ROT_W-1:0] rot_z;
    logic signed [VAL_W-1:0] val_w;
    logic signed [VAL_W-1:0] val_x;
    logic signed [VAL_W-1:0] val_y;
    logic signed [VAL_W-1:0] val_z;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_w;
    logic signed [VAL_W-1:0] out_x;
    logic signed [VAL_W-1:0] out_y;
    logic signed [VAL_W-1:0] out_z;
    logic                    saturated;
  } result_t;

endpackage

>>> rtl/core/qsr_outer.sv
// Registered 4x4 array of signed products a[t] * b[j].
// Depends on nothing outside this file.
module qsr_outer #(
  parameter int AW = 16,
  parameter int BW = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     vld_in,
  input  logic signed [AW-1:0]     a [4],
  input  logic signed [BW-1:0]     b [4],
  output logic                     vld_out,
  output logic signed [AW+BW-1:0]  prod [4][4]
);

  localparam int PW = AW + BW;

  logic signed [PW-1:0] prod_next [4][4];

  always_comb begin
    for (int t = 0; t < 4; t++) begin
      for (int j = 0; j < 4; j++) begin
        prod_next[t][j] = PW'(a[t]) * PW'(b[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
  end

  // Capture only live transactions.
  always_ff @(posedge clk) begin
    if (vld_in) begin
      prod <= prod_next;
    end
  end

endmodule

>>> rtl/core/qsr_hsum.sv
// Registered signed sums that close a Hamilton product from its 16 terms.
// Depends on qsr_pkg for the subtract-flag type.
module qsr_hsum #(
  parameter int PW = 40,
  parameter int SW = 42
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   vld_in,
  input  logic signed [PW-1:0]   prod [4][4],
  input  qsr_pkg::neg_map_t      neg_map,
  output logic                   vld_out,
  output logic signed [SW-1:0]   sum [4]
);

  logic signed [SW-1:0] sum_next [4];

  always_comb begin
    logic signed [SW-1:0] acc;
    logic signed [SW-1:0] term;
    for (int c = 0; c < 4; c++) begin
      acc = '0;
      for (int t = 0; t < 4; t++) begin
        term = SW'(prod[2'(t)][2'(t ^ c)]);
        if (neg_map[2'(c)][2'(t)]) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      sum_next[c] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_in) begin
      sum <= sum_next;
    end
  end

endmodule

>>> rtl/core/qsr_round.sv
// Round half up, drop 2*FRAC fraction bits and saturate each component.
// Depends on qsr_pkg for widths and the result struct.
module qsr_round #(
  parameter int FRAC = 14
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                vld_in,
  input  logic signed [qsr_pkg::SUM2_W-1:0]   sum [4],
  output logic                                vld_out,
  output qsr_pkg::result_t                    result
);

  localparam int S   = 2 * FRAC;
  localparam int RW  = qsr_pkg::SUM2_W + 1;
  localparam int VW  = qsr_pkg::VAL_W;
  localparam logic signed [RW-1:0] HALF = RW'(1) <<< (S - 1);
  localparam logic signed [RW-1:0] VMAX = (RW'(1) <<< (VW - 1)) - RW'(1);
  localparam logic signed [RW-1:0] VMIN = -VMAX - RW'(1);

  logic signed [VW-1:0] comp [4];
  logic [3:0]           clip;
  qsr_pkg::result_t     result_next;

  always_comb begin
    logic signed [RW-1:0] rnd;
    logic signed [RW-1:0] shr;
    for (int c = 0; c < 4; c++) begin
      rnd = RW'(sum[c]) + HALF;
      shr = rnd >>> S;
      if (shr > VMAX) begin
        comp[c] = VMAX[VW-1:0];
        clip[c] = 1'b1;
      end else if (shr < VMIN) begin
        comp[c] = VMIN[VW-1:0];
        clip[c] = 1'b1;
      end else begin
        comp[c] = shr[VW-1:0];
        clip[c] = 1'b0;
      end
    end
    result_next.out_w     = comp[0];
    result_next.out_x     = comp[1];
    result_next.out_y     = comp[2];
    result_next.out_z     = comp[3];
    result_next.saturated = |clip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_in) begin
      result <= result_next;
    end
  end

endmodule

>>> rtl/core/quaternion_sandwich_rotate_core.sv
// Top level of the quaternion sandwich rotation pipeline (q * v * conj(q)).
// Depends on qsr_pkg, assert_macros.svh, qsr_outer, qsr_hsum and qsr_round.
//
// Usage:
//   Command channel: drive item and raise start; a transaction is taken at
//   every rising edge with start high and busy low. busy stays low, so a new
//   transaction may enter every cycle.
//   Result channel: done is high for exactly one cycle with result valid in
//   that cycle; results leave in the order the commands came in. The receiver
//   cannot stall, and none is needed since nothing ever waits in the pipeline.
//   Pipeline stages, each registered, from the accepting edge to done:
//     stage 1: 16 products q[t] * v[j]      (16 x 24 bit)
//     stage 2: first Hamilton sums p        (42 bit)
//     stage 3: 16 products p[t] * q[j]      (42 x 16 bit, the longest path)
//     stage 4: second Hamilton sums         (60 bit)
//     stage 5: round half up, shift by 2*QUAT_FRAC_BITS, saturate
//   Throughput: one transaction per cycle, set by the fully pipelined
//   multiplier arrays of stages 1 and 3.
//   Reset: rst clears every stage valid bit; transactions in flight are
//   dropped and no done follows them. Data registers are not reset.
//   A rotation quaternion of non-unit length scales the result by |q|^2.
`include "assert_macros.svh"

module quaternion_sandwich_rotate_core #(
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  qsr_pkg::item_t     item,
  output logic               done,
  output qsr_pkg::result_t   result
);

  localparam int RW  = qsr_pkg::ROT_W;
  localparam int VW  = qsr_pkg::VAL_W;
  localparam int P1W = qsr_pkg::PROD1_W;
  localparam int S1W = qsr_pkg::SUM1_W;
  localparam int P2W = qsr_pkg::PROD2_W;
  localparam int S2W = qsr_pkg::SUM2_W;

  logic                  accept;
  logic signed [RW-1:0]  q_in [4];
  logic signed [VW-1:0]  v_in [4];

  // Rotation quaternion travels alongside stages 1 and 2 for the second product.
  logic signed [RW-1:0]  q1 [4];
  logic signed [RW-1:0]  q2 [4];

  logic                  vld1, vld2, vld3, vld4;
  logic signed [P1W-1:0] prod1 [4][4];
  logic signed [S1W-1:0] p2 [4];
  logic signed [P2W-1:0] prod3 [4][4];
  logic signed [S2W-1:0] r4 [4];

  // Never hold off a command: every stage advances each cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign q_in[0] = item.rot_w;
  assign q_in[1] = item.rot_x;
  assign q_in[2] = item.rot_y;
  assign q_in[3] = item.rot_z;
  assign v_in[0] = item.val_w;
  assign v_in[1] = item.val_x;
  assign v_in[2] = item.val_y;
  assign v_in[3] = item.val_z;

  always_ff @(posedge clk) begin
    if (accept) begin
      q1 <= q_in;
    end
    if (vld1) begin
      q2 <= q1;
    end
  end

  // Stage 1: all partial products of q * v.
  qsr_outer #(.AW(RW), .BW(VW)) u_mul_first (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (accept),
    .a       (q_in),
    .b       (v_in),
    .vld_out (vld1),
    .prod    (prod1)
  );

  // Stage 2: p = q * v.
  qsr_hsum #(.PW(P1W), .SW(S1W)) u_sum_first (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (vld1),
    .prod    (prod1),
    .neg_map (qsr_pkg::NEG_FIRST),
    .vld_out (vld2),
    .sum     (p2)
  );

  // Stage 3: all partial products of p with q; conjugation lives in the sign map.
  qsr_outer #(.AW(S1W), .BW(RW)) u_mul_second (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (vld2),
    .a       (p2),
    .b       (q2),
    .vld_out (vld3),
    .prod    (prod3)
  );

  // Stage 4: p * conj(q) at full precision.
  qsr_hsum #(.PW(P2W), .SW(S2W)) u_sum_second (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (vld3),
    .prod    (prod3),
    .neg_map (qsr_pkg::NEG_SECOND),
    .vld_out (vld4),
    .sum     (r4)
  );

  // Stage 5: round, scale down and clip into the output register.
  qsr_round #(.FRAC(QUAT_FRAC_BITS)) u_round (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (vld4),
    .sum     (r4),
    .vld_out (done),
    .result  (result)
  );

  `QSR_ASSERT(a_done_follows_cmd, accept |-> ##5 done,
              "accepted transaction produced no result after five cycles")
  `QSR_ASSERT(a_done_has_cmd, done |-> $past(accept, 5),
              "result strobe without a transaction five cycles earlier")
  `QSR_ASSERT(a_sat_at_bound,
              (done && result.saturated) |->
                (result.out_w == {1'b0, {(VW-1){1'b1}}} ||
                 result.out_w == {1'b1, {(VW-1){1'b0}}} ||
                 result.out_x == {1'b0, {(VW-1){1'b1}}} ||
                 result.out_x == {1'b1, {(VW-1){1'b0}}} ||
                 result.out_y == {1'b0, {(VW-1){1'b1}}} ||
                 result.out_y == {1'b1, {(VW-1){1'b0}}} ||
                 result.out_z == {1'b0, {(VW-1){1'b1}}} ||
                 result.out_z == {1'b1, {(VW-1){1'b0}}}),
              "saturation flagged but no component sits at a bound")
  `QSR_ASSERT_ALWAYS(a_no_done_after_reset, $past(rst) |-> !done,
              "result strobe in the cycle after reset")

endmodule

>>> verif/qsr_rotation_checker.sv
`timescale 1ns / 1ps
// Rotation checker: predicts q * v * conj(q) for every accepted command and
// compares each done result against it in order. Depends on qsr_pkg.
module qsr_rotation_checker #(
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  qsr_pkg::item_t   item,
  input  logic             done,
  input  qsr_pkg::result_t result,
  output int               mismatch_count,
  output int               rotations_pending
);

  localparam int SHIFT = 2 * QUAT_FRAC_BITS;
  localparam int VAL_W = qsr_pkg::VAL_W;

  qsr_pkg::result_t expected_rotations [$];
  qsr_pkg::result_t want;

  // Full-precision sandwich product, round half up, shift, clip.
  function automatic qsr_pkg::result_t rotate_expected(input qsr_pkg::item_t it);
    longint qw, qx, qy, qz, vw, vx, vy, vz, pw, px, py, pz;
    longint acc [0:3];
    longint vmax, vmin;
    qsr_pkg::result_t res;
    qw = $signed(it.rot_w);
    qx = $signed(it.rot_x);
    qy = $signed(it.rot_y);
    qz = $signed(it.rot_z);
    vw = $signed(it.val_w);
    vx = $signed(it.val_x);
    vy = $signed(it.val_y);
    vz = $signed(it.val_z);
    // p = q * v
    pw = qw * vw - qx * vx - qy * vy - qz * vz;
    px = qw * vx + qx * vw + qy * vz - qz * vy;
    py = qw * vy - qx * vz + qy * vw + qz * vx;
    pz = qw * vz + qx * vy - qy * vx + qz * vw;
    // p * conj(q), conjugate signs folded in
    acc[0] =  pw * qw + px * qx + py * qy + pz * qz;
    acc[1] = -pw * qx + px * qw - py * qz + pz * qy;
    acc[2] = -pw * qy + px * qz + py * qw - pz * qx;
    acc[3] = -pw * qz - px * qy + py * qx + pz * qw;
    vmax = (64'sd1 <<< (VAL_W - 1)) - 1;
    vmin = -vmax - 1;
    res.saturated = 1'b0;
    for (int c = 0; c < 4; c++) begin
      acc[c] = (acc[c] + (64'sd1 <<< (SHIFT - 1))) >>> SHIFT;
      if (acc[c] > vmax) begin
        acc[c] = vmax;
        res.saturated = 1'b1;
      end else if (acc[c] < vmin) begin
        acc[c] = vmin;
        res.saturated = 1'b1;
      end
    end
    res.out_w = acc[0][VAL_W-1:0];
    res.out_x = acc[1][VAL_W-1:0];
    res.out_y = acc[2][VAL_W-1:0];
    res.out_z = acc[3][VAL_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string field, input logic [VAL_W-1:0] exp_val,
                             input logic [VAL_W-1:0] act_val);
    if (act_val !== exp_val) begin
      if (mismatch_count < 10)
        $display("%0t: %s mismatch: expected %h, actual %h", $realtime, field,
                 exp_val, act_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        expected_rotations.push_back(rotate_expected(item));
      if (done) begin
        if (expected_rotations.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: result with no command outstanding: %h", $realtime, result);
          mismatch_count++;
        end else begin
          want = expected_rotations.pop_front();
          check_field("out_w", want.out_w, result.out_w);
          check_field("out_x", want.out_x, result.out_x);
          check_field("out_y", want.out_y, result.out_y);
          check_field("out_z", want.out_z, result.out_z);
          check_field("saturated", VAL_W'(want.saturated), VAL_W'(result.saturated));
        end
      end
      rotations_pending <= expected_rotations.size();
    end
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for quaternion_sandwich_rotate_core: drives the command
// channel and gives the verdict. Depends on qsr_pkg, qsr_rotation_checker and the core.
module tb_top;

  localparam int QUAT_FRAC_BITS = 14;
  localparam int ROT_W          = qsr_pkg::ROT_W;
  localparam int VAL_W          = qsr_pkg::VAL_W;
  localparam int RANDOM_ITEMS   = 830;
  // no idling over the last stretch of the random part
  localparam int CALM_TAIL      = 120;
  // longest gap is the longest idle burst plus the pipeline delay; allow plenty of headroom
  localparam int WATCHDOG_LIMIT = 1000;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  qsr_pkg::item_t   item;
  logic             done;
  qsr_pkg::result_t result;

  int mismatch_count;
  int rotations_pending;
  int idle_cycles;

  quaternion_sandwich_rotate_core #(
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .done  (done),
    .result(result)
  );

  qsr_rotation_checker #(
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
  ) u_checker (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .item             (item),
    .done             (done),
    .result           (result),
    .mismatch_count   (mismatch_count),
    .rotations_pending(rotations_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Build one command from plain integers; each field takes the low bits.
  function automatic qsr_pkg::item_t make_item(input int rw, input int rx, input int ry,
                                               input int rz, input int vw, input int vx,
                                               input int vy, input int vz);
    qsr_pkg::item_t it;
    it.rot_w = rw[ROT_W-1:0];
    it.rot_x = rx[ROT_W-1:0];
    it.rot_y = ry[ROT_W-1:0];
    it.rot_z = rz[ROT_W-1:0];
    it.val_w = vw[VAL_W-1:0];
    it.val_x = vx[VAL_W-1:0];
    it.val_y = vy[VAL_W-1:0];
    it.val_z = vz[VAL_W-1:0];
    return it;
  endfunction

  // Random signed value, shrunk by a random amount so magnitudes spread out.
  function automatic logic [VAL_W-1:0] random_value(input int max_shrink);
    int t;
    t = $urandom;
    t = t >>> (32 - VAL_W + $urandom_range(max_shrink));
    return t[VAL_W-1:0];
  endfunction

  function automatic logic [ROT_W-1:0] edge_rot();
    case ($urandom_range(6))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'h4000;
      5: return 16'hc000;
      default: return ROT_W'($urandom);
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] edge_val();
    case ($urandom_range(5))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'h000000;
      3: return 24'hffffff;
      4: return 24'h000001;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Pick one random command. Most are well-formed rotations (near unit length,
  // or a point with zero real part); the rest are raw noise and field extremes.
  function automatic qsr_pkg::item_t random_rotation_item();
    logic [ROT_W-1:0] r [0:3];
    logic [VAL_W-1:0] v [0:3];
    int kind;
    int axis;
    int mag;
    qsr_pkg::item_t it;
    kind = $urandom_range(99);
    axis = $urandom_range(3);
    for (int c = 0; c < 4; c++) begin
      if (kind < 25) begin
        // raw noise: every bit of every field is random here
        r[c] = ROT_W'($urandom);
        v[c] = VAL_W'($urandom);
      end else if (kind < 60) begin
        // close to a unit quaternion with one dominant part
        if (c == axis) begin
          mag  = 16384 - $urandom_range(600);
          r[c] = $urandom_range(1) ? mag[ROT_W-1:0] : ROT_W'(-mag);
        end else begin
          mag  = $urandom_range(8000) - 4000;
          r[c] = mag[ROT_W-1:0];
        end
        v[c] = random_value(12);
      end else if (kind < 85) begin
        // point rotation: zero real part on the value side
        mag  = $urandom_range(23170) - 11585;
        r[c] = mag[ROT_W-1:0];
        v[c] = (c == 0) ? '0 : random_value(14);
      end else begin
        r[c] = edge_rot();
        v[c] = edge_val();
      end
    end
    it.rot_w = r[0];
    it.rot_x = r[1];
    it.rot_y = r[2];
    it.rot_z = r[3];
    it.val_w = v[0];
    it.val_x = v[1];
    it.val_y = v[2];
    it.val_z = v[3];
    return it;
  endfunction

  // Present one command and hold it until the core takes it. busy is checked
  // at the falling edge, where it is stable, so the next rising edge accepts.
  task automatic send_rotation(input qsr_pkg::item_t it);
    item  <= it;
    start <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // Drop start for a burst; scramble the data lines meanwhile so a core that
  // samples them without start shows up as a mismatch.
  task automatic idle_burst(input int cycles);
    start <= 1'b0;
    repeat (cycles) begin
      item <= random_rotation_item();
      @(posedge clk);
    end
  endtask

  // Watchdog: end the run when no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("FAIL quaternion_sandwich_rotate_core");
        $finish;
      end
    end
  end

  initial begin
    int idle_pct;
    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: identity, half turns about each axis, a quarter turn,
    // rounding ties in both directions, non-unit scaling and saturation.
    send_rotation(make_item(0, 0, 0, 0, 0, 0, 0, 0));
    send_rotation(make_item(16384, 0, 0, 0, 1, 2, 3, 4));
    send_rotation(make_item(16384, 0, 0, 0, 8388607, 8388607, 8388607, 8388607));
    idle_burst(3);
    send_rotation(make_item(16384, 0, 0, 0, -8388608, -8388608, -8388608, -8388608));
    send_rotation(make_item(-16384, 0, 0, 0, 12345, -54321, 777, -999999));
    send_rotation(make_item(0, 16384, 0, 0, 0, 100, 200, 300));
    send_rotation(make_item(0, 0, 16384, 0, 0, 100, 200, 300));
    idle_burst(1);
    send_rotation(make_item(0, 0, 0, 16384, 0, 100, 200, 300));
    send_rotation(make_item(11585, 0, 0, 11585, 0, 1000000, 0, 0));
    // |q|^2 of 2^-2 scales 2 down to exactly one half: rounds up to 1
    send_rotation(make_item(8192, 0, 0, 0, 2, 2, 2, 2));
    // and minus one half rounds up to 0
    send_rotation(make_item(8192, 0, 0, 0, -2, -2, -2, -2));
    idle_burst(14);
    send_rotation(make_item(-32768, -32768, -32768, -32768,
                            8388607, 8388607, 8388607, 8388607));
    send_rotation(make_item(32767, 32767, 32767, 32767,
                            -8388608, -8388608, -8388608, -8388608));
    send_rotation(make_item(-32768, -32768, -32768, -32768,
                            -8388608, -8388608, -8388608, -8388608));
    send_rotation(make_item(-32768, 0, 0, 0, 1, -1, 5, -5));
    send_rotation(make_item(32767, 32767, -32768, -32768,
                            8388607, -8388608, 8388607, -8388608));
    // about 4x scale: just under, then over the output range
    send_rotation(make_item(32767, 0, 0, 0, 2000000, -2000000, 2000000, -2000000));
    send_rotation(make_item(32767, 0, 0, 0, 3000000, -3000000, 1, 0));
    send_rotation(make_item(1, 1, 1, 1, 1, 1, 1, 1));
    send_rotation(make_item(-1, -1, -1, -1, 8388607, -8388608, 8388607, -8388608));
    idle_burst(2);

    // Random part: idle pressure changes every hundred commands, with some
    // stretches fully back to back, and none at all in the tail.
    idle_pct = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0)
        idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 50);
      send_rotation(random_rotation_item());
      if (n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(99) < idle_pct)
        idle_burst($urandom_range(1, 14));
    end
    start <= 1'b0;

    // Drain: wait for every outstanding result, then keep the clock running so a
    // stray extra result would still be seen.
    @(negedge clk);
    while (rotations_pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);

    if (mismatch_count == 0 && rotations_pending == 0) begin
      $display("PASS quaternion_sandwich_rotate_core");
    end else begin
      $display("FAIL quaternion_sandwich_rotate_core");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/qsr_pkg.sv
rtl/core/qsr_outer.sv
rtl/core/qsr_hsum.sv
rtl/core/qsr_round.sv
rtl/core/quaternion_sandwich_rotate_core.sv
verif/qsr_rotation_checker.sv
verif/tb_top.sv
